/* hdl/wdbd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wdbd_pkg: shared types and constants for the working-day counter
// calendar tables, field widths, sequencer states and reciprocal constants
// ----------------------------------------------------------------------------
package wdbd_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int MASK_W  = 7;
    localparam int COUNT_W = 17;
    localparam int WD_W    = 3;

    // shifted year, day numbers and spans
    localparam int YS_W  = 13;
    localparam int NUM_W = 21;
    localparam int MS_W  = 4;
    localparam int Q100_W = 6;

    // shared multiplier
    localparam int MUL_W  = 22;
    localparam int PROD_W = 2 * MUL_W;

    localparam int IN_W  = 2 * (YEAR_W + MONTH_W + DAY_W);
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((COUNT_W + 7) / 8) * 8;
    localparam int DATE_W = YEAR_W + MONTH_W + DAY_W;

    // x / 100 = (x * RECIP_100) >> SHIFT_100, exact for x below 8192
    localparam logic [MUL_W-1:0] RECIP_100 = MUL_W'(5243);
    localparam int SHIFT_100 = 19;
    // x / 7 = (x * RECIP_7) >> SHIFT_7, exact for x below 2**21
    localparam logic [MUL_W-1:0] RECIP_7 = MUL_W'(2396746);
    localparam int SHIFT_7 = 24;
    localparam logic [MUL_W-1:0] DAYS_PER_YEAR = MUL_W'(365);

    localparam logic [YS_W-1:0]  YEAR_SHIFT = YS_W'(400);
    localparam logic [NUM_W-1:0] WD_OFFSET  = NUM_W'(3);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [MASK_W-1:0]  MASK_RESET = MASK_W'(96);

    // one-hot sequencer states
    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_YDIV   = 13'b0000000000010,
        ST_CLAMP  = 13'b0000000000100,
        ST_YSDIV  = 13'b0000000001000,
        ST_YS365  = 13'b0000000010000,
        ST_NUM    = 13'b0000000100000,
        ST_WK     = 13'b0000001000000,
        ST_WKR    = 13'b0000010000000,
        ST_SPAN   = 13'b0000100000000,
        ST_Q7     = 13'b0001000000000,
        ST_MULW   = 13'b0010000000000,
        ST_REM    = 13'b0100000000000,
        ST_FINISH = 13'b1000000000000
    } wdbd_state_t;

    // length of a month that is not february, month 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        begin
            case (m)
                4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
                4'd2:                    len = DAY_W'(28);
                default:                 len = DAY_W'(31);
            endcase
            return len;
        end
    endfunction

    // days before month ms of a year starting in march, (153*ms+2)/5
    function automatic logic [8:0] march_offset(input logic [MS_W-1:0] ms);
        logic [8:0] ofs;
        begin
            case (ms)
                4'd0:    ofs = 9'd0;
                4'd1:    ofs = 9'd31;
                4'd2:    ofs = 9'd61;
                4'd3:    ofs = 9'd92;
                4'd4:    ofs = 9'd122;
                4'd5:    ofs = 9'd153;
                4'd6:    ofs = 9'd184;
                4'd7:    ofs = 9'd214;
                4'd8:    ofs = 9'd245;
                4'd9:    ofs = 9'd275;
                4'd10:   ofs = 9'd306;
                4'd11:   ofs = 9'd337;
                default: ofs = 9'd0;
            endcase
            return ofs;
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/wdbd_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wdbd_mul: shared multiplier
// unsigned product of two operands, registered for use in the next cycle
// ----------------------------------------------------------------------------
module wdbd_mul (
    input  wire logic                         aclk,
    input  wire logic [wdbd_pkg::MUL_W-1:0]   mul_a,
    input  wire logic [wdbd_pkg::MUL_W-1:0]   mul_b,
    output logic      [wdbd_pkg::PROD_W-1:0]  prod
);
    import wdbd_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

/* hdl/working_days_between_dates.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// working_days_between_dates: counts non-weekend days from start to end date
// dates go to day numbers and the span is split into whole weeks and leftover
// ----------------------------------------------------------------------------
// an empty span skips the week split; otherwise the leftover days (0..6) are walked
// one item in work at a time: s_tready is high only in idle
// each item makes up to nine passes through the shared multiplier, then the leftover-day walk
// a finished result waits in the output register while the next item enters
// reset (aresetn low, synchronous) returns to idle, drops m_tvalid and sets
// the weekend mask to friday and saturday
module working_days_between_dates (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration: weekend mask, bit n marks weekday n (0 sunday)
    input  wire logic                              cfg_we,
    input  wire logic [wdbd_pkg::MASK_W-1:0]       cfg_wdata,
    // input dates
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // start_year, start_month, start_day, end_year, end_month, end_day
    input  wire logic [wdbd_pkg::IN_TDATA_W-1:0]   s_tdata,
    // result
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // working_days
    output logic      [wdbd_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import wdbd_pkg::*;

    wdbd_state_t state_reg, state_next;

    logic [MASK_W-1:0]  mask_reg;
    logic [IN_W-1:0]    in_reg;
    logic               sel_reg, sel_next;     // 0 start date, 1 end date
    logic [YS_W-1:0]    ys_reg, ys_next;
    logic [MS_W-1:0]    ms_reg, ms_next;
    logic [DAY_W-1:0]   d_reg, d_next;
    logic [Q100_W-1:0]  q100_reg, q100_next;
    logic [NUM_W-1:0]   sn_reg, sn_next;
    logic [NUM_W-1:0]   en_reg, en_next;
    logic [NUM_W-1:0]   span_reg, span_next;
    logic [WD_W-1:0]    wd_reg, wd_next;
    logic [WD_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]   count_reg, count_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [COUNT_W-1:0] m_data_reg, m_data_next;

    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  prod;

    // fields of the date in work
    logic [DATE_W-1:0]  date_cur;
    logic [YEAR_W-1:0]  y_cur;
    logic [MONTH_W-1:0] m_raw, m_clamp;
    logic [DAY_W-1:0]   d_raw, d_clamp, len;
    logic [Q100_W-1:0]  y_q100;
    logic [YEAR_W-1:0]  y_r100;
    logic               leap;
    logic [NUM_W-1:0]   num;
    logic [NUM_W-1:0]   wd_x;
    logic [NUM_W-1:0]   quot7;
    logic [NUM_W-1:0]   diff7;
    logic [WD_W-1:0]    per_week;

    wdbd_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    // start date sits in the low half, end date in the high half
    assign date_cur = sel_reg ? in_reg[IN_W-1:DATE_W] : in_reg[DATE_W-1:0];
    assign y_cur    = date_cur[YEAR_W-1:0];
    assign m_raw    = date_cur[YEAR_W+MONTH_W-1:YEAR_W];
    assign d_raw    = date_cur[DATE_W-1:YEAR_W+MONTH_W];

    // leap rule from y/100 out of the multiplier
    assign y_q100 = prod[SHIFT_100+Q100_W-1:SHIFT_100];
    assign y_r100 = y_cur - YEAR_W'(y_q100) * YEAR_W'(100);
    assign leap   = ((y_cur[1:0] == 2'b00) && (y_r100 != '0))
                 || ((y_r100 == '0) && (y_q100[1:0] == 2'b00));

    // out-of-range months and days are pulled to the nearest valid value
    always_comb begin
        if (m_raw == '0) begin
            m_clamp = MONTH_W'(1);
        end else if (m_raw > MONTH_W'(12)) begin
            m_clamp = MONTH_W'(12);
        end else begin
            m_clamp = m_raw;
        end
        if (m_clamp == MONTH_W'(2)) begin
            len = leap ? DAY_W'(29) : DAY_W'(28);
        end else begin
            len = month_len(m_clamp);
        end
        if (d_raw == '0) begin
            d_clamp = DAY_W'(1);
        end else if (d_raw > len) begin
            d_clamp = len;
        end else begin
            d_clamp = d_raw;
        end
    end

    // day number once 365*ys is in the multiplier
    assign num = prod[NUM_W-1:0] + NUM_W'(ys_reg >> 2) - NUM_W'(q100_reg)
               + NUM_W'(q100_reg >> 2) + NUM_W'(march_offset(ms_reg))
               + NUM_W'(d_reg) - NUM_W'(1);

    // weekday of the start date is (day number + 3) mod 7
    assign wd_x  = sn_reg + WD_OFFSET;
    assign quot7 = NUM_W'(prod[PROD_W-1:SHIFT_7]);
    assign diff7 = (state_reg == ST_WKR) ? wd_x : span_reg;

    // working days in a whole week
    assign per_week = WD_W'($countones(~mask_reg));

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_YDIV: begin
                mul_a = MUL_W'(y_cur);
                mul_b = RECIP_100;
            end
            ST_YSDIV: begin
                mul_a = MUL_W'(ys_reg);
                mul_b = RECIP_100;
            end
            ST_YS365: begin
                mul_a = MUL_W'(ys_reg);
                mul_b = DAYS_PER_YEAR;
            end
            ST_WK: begin
                mul_a = MUL_W'(wd_x);
                mul_b = RECIP_7;
            end
            ST_SPAN: begin
                mul_a = MUL_W'(en_reg - sn_reg);
                mul_b = RECIP_7;
            end
            ST_Q7: begin
                mul_a = MUL_W'(quot7);
                mul_b = MUL_W'(per_week);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        ys_next       = ys_reg;
        ms_next       = ms_reg;
        d_next        = d_reg;
        q100_next     = q100_reg;
        sn_next       = sn_reg;
        en_next       = en_reg;
        span_next     = span_reg;
        wd_next       = wd_reg;
        rem_next      = rem_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sel_next   = 1'b0;
                    state_next = ST_YDIV;
                end
            end
            ST_YDIV: begin
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                // january and february belong to the year before
                d_next = d_clamp;
                if (m_clamp <= MONTH_W'(2)) begin
                    ys_next = YS_W'(y_cur) + YEAR_SHIFT - YS_W'(1);
                    ms_next = m_clamp + MS_W'(9);
                end else begin
                    ys_next = YS_W'(y_cur) + YEAR_SHIFT;
                    ms_next = m_clamp - MS_W'(3);
                end
                state_next = ST_YSDIV;
            end
            ST_YSDIV: begin
                state_next = ST_YS365;
            end
            ST_YS365: begin
                q100_next  = prod[SHIFT_100+Q100_W-1:SHIFT_100];
                state_next = ST_NUM;
            end
            ST_NUM: begin
                if (!sel_reg) begin
                    sn_next    = num;
                    state_next = ST_WK;
                end else begin
                    en_next    = num;
                    state_next = ST_SPAN;
                end
            end
            ST_WK: begin
                state_next = ST_WKR;
            end
            ST_WKR: begin
                wd_next    = WD_W'(diff7 - ((quot7 << 3) - quot7));
                sel_next   = 1'b1;
                state_next = ST_YDIV;
            end
            ST_SPAN: begin
                if (sn_reg >= en_reg) begin
                    count_next = '0;
                    rem_next   = '0;
                    state_next = ST_FINISH;
                end else begin
                    span_next  = en_reg - sn_reg;
                    state_next = ST_Q7;
                end
            end
            ST_Q7: begin
                rem_next   = WD_W'(diff7 - ((quot7 << 3) - quot7));
                state_next = ST_MULW;
            end
            ST_MULW: begin
                count_next = prod[NUM_W-1:0];
                state_next = ST_REM;
            end
            ST_REM: begin
                // leftover days, one per cycle from the start weekday
                if (rem_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    if (!mask_reg[wd_reg]) begin
                        count_next = count_reg + NUM_W'(1);
                    end
                    wd_next  = (wd_reg == WD_W'(6)) ? '0 : wd_reg + WD_W'(1);
                    rem_next = rem_reg - WD_W'(1);
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = (count_reg > NUM_W'(COUNT_MAX))
                                  ? COUNT_MAX : count_reg[COUNT_W-1:0];
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            mask_reg     <= MASK_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                mask_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= s_tdata[IN_W-1:0];
        end
        sel_reg    <= sel_next;
        ys_reg     <= ys_next;
        ms_reg     <= ms_next;
        d_reg      <= d_next;
        q100_reg   <= q100_next;
        sn_reg     <= sn_next;
        en_reg     <= en_next;
        span_reg   <= span_next;
        wd_reg     <= wd_next;
        rem_reg    <= rem_next;
        count_reg  <= count_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(m_data_reg);

endmodule
`default_nettype wire
